@@ rtl/qrs_pkg.sv @@
// ============================================================================
// qrs_pkg - shared widths for the quadratic root solver
// Word, fraction and derived datapath widths used by the top level and cells.
// ============================================================================
package qrs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;

    // magnitude of one coefficient (holds the most negative word)
    localparam int MAG_W   = WORD_BITS + 1;
    // product of two magnitudes
    localparam int PROD_W  = 2 * WORD_BITS;
    // discriminant magnitude, even so that it splits into bit pairs
    localparam int RAD_W   = PROD_W + 4;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int SQREM_W = ROOT_W + 4;
    // numerator -b +/- sqrt(D) and denominator 2a or b
    localparam int NUM_W   = ROOT_W + 2;
    localparam int DEN_W   = WORD_BITS + 2;
    // numerator magnitude scaled by 2^FRAC_BITS
    localparam int NMAG_W  = NUM_W + FRAC_BITS;
    // divisor shifted up to the top quotient bit
    localparam int DSH_W   = MAG_W + WORD_BITS - 1;
    localparam int CMP_W   = (NMAG_W > DSH_W) ? NMAG_W : DSH_W;

    // root count codes
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_INF  = 2'd3;

endpackage

@@ rtl/qrs_sqrt_cell.sv @@
// ============================================================================
// qrs_sqrt_cell - one bit of the floored square root
// Shift in the next radicand bit pair, try the trial divisor, emit a root bit.
// ============================================================================
module qrs_sqrt_cell (
    input  logic                        i_clk,
    input  logic [qrs_pkg::RAD_W-1:0]   i_rad,
    input  logic [qrs_pkg::SQREM_W-1:0] i_rem,
    input  logic [qrs_pkg::ROOT_W-1:0]  i_root,
    output logic [qrs_pkg::RAD_W-1:0]   o_rad,
    output logic [qrs_pkg::SQREM_W-1:0] o_rem,
    output logic [qrs_pkg::ROOT_W-1:0]  o_root
);
    import qrs_pkg::*;

    logic [SQREM_W-1:0] rem_sh;
    logic [SQREM_W-1:0] trial;
    logic               ge;
    logic [RAD_W-1:0]   n_rad;
    logic [SQREM_W-1:0] n_rem;
    logic [ROOT_W-1:0]  n_root;
    logic [RAD_W-1:0]   r_rad;
    logic [SQREM_W-1:0] r_rem;
    logic [ROOT_W-1:0]  r_root;

    always_comb begin
        rem_sh = {i_rem[SQREM_W-3:0], i_rad[RAD_W-1 -: 2]};
        trial  = {2'b00, i_root, 2'b01};
        ge     = (rem_sh >= trial);
        n_rem  = ge ? (rem_sh - trial) : rem_sh;
        n_root = {i_root[ROOT_W-2:0], ge};
        n_rad  = {i_rad[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

@@ rtl/qrs_div_cell.sv @@
// ============================================================================
// qrs_div_cell - one quotient bit of a restoring divider
// Compare the partial remainder with the shifted divisor and subtract on a hit.
// ============================================================================
module qrs_div_cell (
    input  logic                          i_clk,
    input  logic [qrs_pkg::NMAG_W-1:0]    i_rem,
    input  logic [qrs_pkg::DSH_W-1:0]     i_dsh,
    input  logic [qrs_pkg::WORD_BITS-1:0] i_quo,
    output logic [qrs_pkg::NMAG_W-1:0]    o_rem,
    output logic [qrs_pkg::DSH_W-1:0]     o_dsh,
    output logic [qrs_pkg::WORD_BITS-1:0] o_quo
);
    import qrs_pkg::*;

    logic [CMP_W-1:0]     rem_x;
    logic [CMP_W-1:0]     dsh_x;
    logic [CMP_W-1:0]     diff;
    logic                 ge;
    logic [NMAG_W-1:0]    n_rem;
    logic [DSH_W-1:0]     n_dsh;
    logic [WORD_BITS-1:0] n_quo;
    logic [NMAG_W-1:0]    r_rem;
    logic [DSH_W-1:0]     r_dsh;
    logic [WORD_BITS-1:0] r_quo;

    always_comb begin
        rem_x = CMP_W'(i_rem);
        dsh_x = CMP_W'(i_dsh);
        diff  = rem_x - dsh_x;
        ge    = (rem_x >= dsh_x);
        n_rem = ge ? diff[NMAG_W-1:0] : i_rem;
        n_dsh = i_dsh >> 1;
        n_quo = {i_quo[WORD_BITS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_quo <= n_quo;
    end

    assign o_rem = r_rem;
    assign o_dsh = r_dsh;
    assign o_quo = r_quo;

endmodule

@@ rtl/quadratic_root_solver.sv @@
// ============================================================================
// quadratic_root_solver - real roots of a*x^2 + b*x + c = 0 in Q16.16
// Throughput: one transaction per cycle; o_busy is always low, since every
// stage (34 square root cells, then 32 divider cells per root) advances
// each cycle and the receiver cannot stall.
// Reset (i_rst_n low, synchronous): drop all transactions in flight and
// clear zero_tolerance to 0.
// ============================================================================
module quadratic_root_solver (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic signed [qrs_pkg::WORD_BITS-1:0] i_coef_a,
    input  logic signed [qrs_pkg::WORD_BITS-1:0] i_coef_b,
    input  logic signed [qrs_pkg::WORD_BITS-1:0] i_coef_c,
    input  logic                                 i_cfg_we,
    input  logic [15:0]                          i_cfg_wdata,
    output logic                                 o_valid,
    output logic signed [qrs_pkg::WORD_BITS-1:0] o_root_minus,
    output logic signed [qrs_pkg::WORD_BITS-1:0] o_root_plus,
    output logic [1:0]                           o_root_count,
    output logic                                 o_overflow
);
    import qrs_pkg::*;

    localparam int W     = WORD_BITS;
    localparam int BIG_W = (NMAG_W > MAG_W + W) ? NMAG_W : MAG_W + W;

    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    // which roots the divider results feed
    typedef enum logic [1:0] {
        M_NONE,
        M_ONE,
        M_TWO
    } t_mode;

    typedef struct packed {
        t_mode                    mode;
        logic [1:0]               count;
        logic signed [NUM_W-1:0]  nb;
        logic signed [DEN_W-1:0]  den;
    } t_sq_side;

    typedef struct packed {
        t_mode      mode;
        logic [1:0] count;
        logic       neg1;
        logic       neg2;
        logic       big1;
        logic       big2;
    } t_dv_side;

    // magnitude of a coefficient, one bit wider so the most negative word fits
    function automatic logic [MAG_W-1:0] coef_mag(input logic [W-1:0] x);
        logic [MAG_W-1:0] e;
        begin
            e = {x[W-1], x};
            coef_mag = x[W-1] ? (~e + 1'b1) : e;
        end
    endfunction

    // saturate a signed quotient; returns {overflow, root}
    function automatic logic [W:0] sat_root(input logic big, input logic neg,
                                            input logic [W-1:0] q);
        logic [W-1:0] nq;
        begin
            nq = ~q + 1'b1;
            if (big) begin
                sat_root = {1'b1, (neg ? MINV : MAXV)};
            end else if (!neg && q[W-1]) begin
                sat_root = {1'b1, MAXV};
            end else if (neg && (q > MINV)) begin
                sat_root = {1'b1, MINV};
            end else begin
                sat_root = {1'b0, (neg ? nq : q)};
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [15:0] r_zero_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_tol <= '0;
        end else if (i_cfg_we) begin
            r_zero_tol <= i_cfg_wdata;
        end
    end

    assign o_busy = 1'b0;

    // ------------------------------------------------------------------
    // stage 1: capture the coefficients
    // ------------------------------------------------------------------
    logic                r_s1_vld;
    logic signed [W-1:0] r_s1_a, r_s1_b, r_s1_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_a <= i_coef_a;
        r_s1_b <= i_coef_b;
        r_s1_c <= i_coef_c;
    end

    // ------------------------------------------------------------------
    // stage 2: b^2 and |a*c|, zero tests of the coefficients
    // ------------------------------------------------------------------
    logic [MAG_W-1:0]   mag_a, mag_b, mag_c;
    logic [2*MAG_W-1:0] prod_bb, prod_ac;

    logic                r_s2_vld;
    logic signed [W-1:0] r_s2_a, r_s2_b, r_s2_c;
    logic                r_s2_za, r_s2_zb, r_s2_zc, r_s2_acneg;
    logic [PROD_W-1:0]   r_s2_b2, r_s2_ac;

    always_comb begin
        mag_a   = coef_mag(r_s1_a);
        mag_b   = coef_mag(r_s1_b);
        mag_c   = coef_mag(r_s1_c);
        prod_bb = mag_b * mag_b;
        prod_ac = mag_a * mag_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_a     <= r_s1_a;
        r_s2_b     <= r_s1_b;
        r_s2_c     <= r_s1_c;
        r_s2_za    <= (mag_a <= MAG_W'(r_zero_tol));
        r_s2_zb    <= (mag_b <= MAG_W'(r_zero_tol));
        r_s2_zc    <= (mag_c <= MAG_W'(r_zero_tol));
        // a*c is negative only when both are nonzero and the signs differ
        r_s2_acneg <= (r_s1_a[W-1] ^ r_s1_c[W-1]) && (r_s1_a != '0) && (r_s1_c != '0);
        r_s2_b2    <= prod_bb[PROD_W-1:0];
        r_s2_ac    <= prod_ac[PROD_W-1:0];
    end

    // ------------------------------------------------------------------
    // stage 3: exact discriminant, split into sign and magnitude
    // ------------------------------------------------------------------
    logic [RAD_W-1:0] b2_x, ac4_x, d_sum, d_neg_sum;

    logic                r_s3_vld;
    logic signed [W-1:0] r_s3_a, r_s3_b, r_s3_c;
    logic                r_s3_za, r_s3_zb, r_s3_zc;
    logic                r_s3_dneg;
    logic [RAD_W-1:0]    r_s3_dmag;

    always_comb begin
        b2_x      = {4'b0000, r_s2_b2};
        ac4_x     = {2'b00, r_s2_ac, 2'b00};
        d_sum     = r_s2_acneg ? (b2_x + ac4_x) : (b2_x - ac4_x);
        d_neg_sum = ~d_sum + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_a    <= r_s2_a;
        r_s3_b    <= r_s2_b;
        r_s3_c    <= r_s2_c;
        r_s3_za   <= r_s2_za;
        r_s3_zb   <= r_s2_zb;
        r_s3_zc   <= r_s2_zc;
        r_s3_dneg <= d_sum[RAD_W-1];
        r_s3_dmag <= d_sum[RAD_W-1] ? d_neg_sum : d_sum;
    end

    // ------------------------------------------------------------------
    // classify the equation and pick numerator base and denominator;
    // this enters the square root chain together with |D|
    // ------------------------------------------------------------------
    t_sq_side                side_in;
    logic                    d_zero;
    logic signed [NUM_W-1:0] b_ext, c_ext;

    always_comb begin
        d_zero        = (r_s3_dmag <= RAD_W'(r_zero_tol));
        b_ext         = NUM_W'(r_s3_b);
        c_ext         = NUM_W'(r_s3_c);
        side_in.mode  = M_NONE;
        side_in.count = CNT_NONE;
        side_in.nb    = -b_ext;
        side_in.den   = {r_s3_a[W-1], r_s3_a, 1'b0};
        if (r_s3_za && r_s3_zb) begin
            side_in.count = r_s3_zc ? CNT_INF : CNT_NONE;
        end else if (r_s3_za) begin
            // linear equation: -c / b
            side_in.mode  = M_ONE;
            side_in.count = CNT_ONE;
            side_in.nb    = -c_ext;
            side_in.den   = DEN_W'(r_s3_b);
        end else if (d_zero) begin
            side_in.mode  = M_ONE;
            side_in.count = CNT_ONE;
        end else if (r_s3_dneg) begin
            side_in.count = CNT_NONE;
        end else begin
            side_in.mode  = M_TWO;
            side_in.count = CNT_TWO;
        end
    end

    // ------------------------------------------------------------------
    // square root chain: one root bit per cell
    // ------------------------------------------------------------------
    logic [RAD_W-1:0]   w_rad  [ROOT_W+1];
    logic [SQREM_W-1:0] w_rem  [ROOT_W+1];
    logic [ROOT_W-1:0]  w_root [ROOT_W+1];

    logic [ROOT_W-1:0] r_sq_vld;
    t_sq_side          r_sq_side [ROOT_W];

    assign w_rad[0]  = r_s3_dmag;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    for (genvar gi = 0; gi < ROOT_W; gi++) begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rad  (w_rad[gi]),
            .i_rem  (w_rem[gi]),
            .i_root (w_root[gi]),
            .o_rad  (w_rad[gi+1]),
            .o_rem  (w_rem[gi+1]),
            .o_root (w_root[gi+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= '0;
        end else begin
            r_sq_vld <= {r_sq_vld[ROOT_W-2:0], r_s3_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_side[0] <= side_in;
        for (int i = 1; i < ROOT_W; i++) begin
            r_sq_side[i] <= r_sq_side[i-1];
        end
    end

    // ------------------------------------------------------------------
    // numerators -b - s and -b + s for two roots, else the numerator base
    // ------------------------------------------------------------------
    t_sq_side                sq_last;
    logic signed [NUM_W-1:0] s_ext;

    logic                    r_n_vld;
    t_mode                   r_n_mode;
    logic [1:0]              r_n_count;
    logic signed [NUM_W-1:0] r_n_num1, r_n_num2;
    logic signed [DEN_W-1:0] r_n_den;

    always_comb begin
        sq_last = r_sq_side[ROOT_W-1];
        s_ext   = $signed({2'b00, w_root[ROOT_W]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_vld <= 1'b0;
        end else begin
            r_n_vld <= r_sq_vld[ROOT_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_n_mode  <= sq_last.mode;
        r_n_count <= sq_last.count;
        r_n_den   <= sq_last.den;
        r_n_num1  <= (sq_last.mode == M_TWO) ? (sq_last.nb - s_ext) : sq_last.nb;
        r_n_num2  <= (sq_last.mode == M_TWO) ? (sq_last.nb + s_ext) : sq_last.nb;
    end

    // ------------------------------------------------------------------
    // divider setup: magnitudes, quotient signs, out-of-range test
    // ------------------------------------------------------------------
    logic [NUM_W-1:0]  nabs1, nabs2;
    logic [DEN_W-1:0]  dabs;
    logic [NMAG_W-1:0] nmag1, nmag2;
    logic [MAG_W-1:0]  dmag;
    logic [BIG_W-1:0]  dlim;

    logic              r_p_vld;
    t_dv_side          r_p_side;
    logic [NMAG_W-1:0] r_p_nmag1, r_p_nmag2;
    logic [MAG_W-1:0]  r_p_dmag;

    always_comb begin
        nabs1 = r_n_num1[NUM_W-1] ? (~r_n_num1 + 1'b1) : r_n_num1;
        nabs2 = r_n_num2[NUM_W-1] ? (~r_n_num2 + 1'b1) : r_n_num2;
        dabs  = r_n_den[DEN_W-1] ? (~r_n_den + 1'b1) : r_n_den;
        nmag1 = {nabs1, {FRAC_BITS{1'b0}}};
        nmag2 = {nabs2, {FRAC_BITS{1'b0}}};
        dmag  = dabs[MAG_W-1:0];
        dlim  = BIG_W'({dmag, {W{1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= r_n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_side.mode  <= r_n_mode;
        r_p_side.count <= r_n_count;
        r_p_side.neg1  <= r_n_num1[NUM_W-1] ^ r_n_den[DEN_W-1];
        r_p_side.neg2  <= r_n_num2[NUM_W-1] ^ r_n_den[DEN_W-1];
        // quotient magnitude would reach 2^W: saturate without dividing
        r_p_side.big1  <= (BIG_W'(nmag1) >= dlim);
        r_p_side.big2  <= (BIG_W'(nmag2) >= dlim);
        r_p_nmag1      <= nmag1;
        r_p_nmag2      <= nmag2;
        r_p_dmag       <= dmag;
    end

    // ------------------------------------------------------------------
    // two divider chains, one quotient bit per cell
    // ------------------------------------------------------------------
    logic [NMAG_W-1:0] w_d1_rem [W+1];
    logic [DSH_W-1:0]  w_d1_dsh [W+1];
    logic [W-1:0]      w_d1_quo [W+1];
    logic [NMAG_W-1:0] w_d2_rem [W+1];
    logic [DSH_W-1:0]  w_d2_dsh [W+1];
    logic [W-1:0]      w_d2_quo [W+1];

    logic [W-1:0] r_dv_vld;
    t_dv_side     r_dv_side [W];

    assign w_d1_rem[0] = r_p_nmag1;
    assign w_d1_dsh[0] = {r_p_dmag, {(W-1){1'b0}}};
    assign w_d1_quo[0] = '0;
    assign w_d2_rem[0] = r_p_nmag2;
    assign w_d2_dsh[0] = {r_p_dmag, {(W-1){1'b0}}};
    assign w_d2_quo[0] = '0;

    for (genvar gk = 0; gk < W; gk++) begin : g_div
        qrs_div_cell u_div1 (
            .i_clk (i_clk),
            .i_rem (w_d1_rem[gk]),
            .i_dsh (w_d1_dsh[gk]),
            .i_quo (w_d1_quo[gk]),
            .o_rem (w_d1_rem[gk+1]),
            .o_dsh (w_d1_dsh[gk+1]),
            .o_quo (w_d1_quo[gk+1])
        );
        qrs_div_cell u_div2 (
            .i_clk (i_clk),
            .i_rem (w_d2_rem[gk]),
            .i_dsh (w_d2_dsh[gk]),
            .i_quo (w_d2_quo[gk]),
            .o_rem (w_d2_rem[gk+1]),
            .o_dsh (w_d2_dsh[gk+1]),
            .o_quo (w_d2_quo[gk+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld <= '0;
        end else begin
            r_dv_vld <= {r_dv_vld[W-2:0], r_p_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_side[0] <= r_p_side;
        for (int i = 1; i < W; i++) begin
            r_dv_side[i] <= r_dv_side[i-1];
        end
    end

    // ------------------------------------------------------------------
    // saturate, pick the roots, register the result
    // ------------------------------------------------------------------
    t_dv_side     dv_last;
    logic [W:0]   sat1, sat2;
    logic [W-1:0] n_root_minus, n_root_plus;
    logic         n_overflow;

    logic               r_valid;
    logic signed [W-1:0] r_root_minus, r_root_plus;
    logic [1:0]         r_root_count;
    logic               r_overflow;

    always_comb begin
        dv_last = r_dv_side[W-1];
        sat1    = sat_root(dv_last.big1, dv_last.neg1, w_d1_quo[W]);
        sat2    = sat_root(dv_last.big2, dv_last.neg2, w_d2_quo[W]);
        case (dv_last.mode)
            M_ONE: begin
                n_root_minus = sat1[W-1:0];
                n_root_plus  = sat1[W-1:0];
                n_overflow   = sat1[W];
            end
            M_TWO: begin
                n_root_minus = sat1[W-1:0];
                n_root_plus  = sat2[W-1:0];
                n_overflow   = sat1[W] | sat2[W];
            end
            default: begin
                n_root_minus = '0;
                n_root_plus  = '0;
                n_overflow   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_dv_vld[W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_root_minus <= n_root_minus;
        r_root_plus  <= n_root_plus;
        r_root_count <= dv_last.count;
        r_overflow   <= n_overflow;
    end

    assign o_valid      = r_valid;
    assign o_root_minus = r_root_minus;
    assign o_root_plus  = r_root_plus;
    assign o_root_count = r_root_count;
    assign o_overflow   = r_overflow;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb - self-checking bench for quadratic_root_solver
// Drives coefficient transactions from a queue, predicts roots with a local
// model of the solver arithmetic and checks every strobed result in order.
// ============================================================================
module tb;
    import qrs_pkg::*;

    localparam int LATENCY    = 72;
    localparam int LIMIT      = 400000;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] a;
        logic signed [WORD_BITS-1:0] b;
        logic signed [WORD_BITS-1:0] c;
    } t_coef;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] rm;
        logic signed [WORD_BITS-1:0] rp;
        logic [1:0]                  cnt;
        logic                        ovf;
    } t_roots;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic o_busy;
    logic signed [WORD_BITS-1:0] i_coef_a = '0, i_coef_b = '0, i_coef_c = '0;
    logic i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic o_valid;
    logic signed [WORD_BITS-1:0] o_root_minus, o_root_plus;
    logic [1:0] o_root_count;
    logic o_overflow;

    t_coef  pending_coefs[$];
    t_roots expected_roots[$];
    logic [15:0] tol = '0;
    int idle_pct = 0;
    int errors = 0;
    int cycles = 0;

    quadratic_root_solver dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_coef_a(i_coef_a), .i_coef_b(i_coef_b), .i_coef_c(i_coef_c),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_valid(o_valid), .o_root_minus(o_root_minus), .o_root_plus(o_root_plus),
        .o_root_count(o_root_count), .o_overflow(o_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Saturating fixed-point divide: (num << FRAC_BITS) / den, truncating.
    function automatic logic signed [WORD_BITS-1:0] sat_div(
        input logic signed [127:0] num, input logic signed [127:0] den,
        inout logic ovf);
        logic signed [127:0] q;
        q = (num <<< FRAC_BITS) / den;
        if (q > 128'sd2147483647) begin
            ovf = 1'b1;
            return 32'h7fffffff;
        end
        if (q < -128'sd2147483648) begin
            ovf = 1'b1;
            return 32'h80000000;
        end
        return q[WORD_BITS-1:0];
    endfunction

    function automatic logic [127:0] floor_sqrt(input logic [127:0] v);
        logic [127:0] r, rem, trial;
        r = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = (rem << 2) | ((v >> (2 * i)) & 128'd3);
            trial = (r << 2) | 128'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                r = (r << 1) | 128'd1;
            end else begin
                r = r << 1;
            end
        end
        return r;
    endfunction

    function automatic logic near_zero(input logic signed [127:0] v);
        logic [127:0] m;
        m = (v < 0) ? -v : v;
        return m <= {112'd0, tol};
    endfunction

    function automatic t_roots solve_roots(input t_coef k);
        t_roots r;
        logic signed [127:0] a, b, c, d, s;
        logic ovf;
        a = k.a;
        b = k.b;
        c = k.c;
        ovf = 1'b0;
        r = '0;
        if (near_zero(a) && near_zero(b)) begin
            r.cnt = near_zero(c) ? CNT_INF : CNT_NONE;
        end else if (near_zero(a)) begin
            r.rm = sat_div(-c, b, ovf);
            r.rp = r.rm;
            r.cnt = CNT_ONE;
        end else begin
            d = b * b - 4 * a * c;
            // a discriminant within the tolerance on either side gives one root
            if (near_zero(d)) begin
                r.rm = sat_div(-b, 2 * a, ovf);
                r.rp = r.rm;
                r.cnt = CNT_ONE;
            end else if (d < 0) begin
                r.cnt = CNT_NONE;
            end else begin
                s = floor_sqrt(d);
                r.rm = sat_div(-b - s, 2 * a, ovf);
                r.rp = sat_div(-b + s, 2 * a, ovf);
                r.cnt = CNT_TWO;
            end
        end
        r.ovf = ovf;
        return r;
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 65535) - 32768;
            2: return (32'($urandom_range(0, 15)) << 16) - 32'h80000;
            3: return ($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
            4: return $urandom_range(0, 8) - 4;
            default: return (32'($urandom_range(0, 255)) << 8) - 32'h8000;
        endcase
    endfunction

    // Driver: launch one transaction from the queue unless idling this cycle.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && pending_coefs.size() != 0 && !o_busy &&
            $urandom_range(0, 99) >= idle_pct) begin
            t_coef k;
            k = pending_coefs.pop_front();
            i_start <= 1'b1;
            i_coef_a <= k.a;
            i_coef_b <= k.b;
            i_coef_c <= k.c;
            expected_roots.push_back(solve_roots(k));
        end else begin
            i_start <= 1'b0;
        end
    end

    // Monitor: compare each strobed result with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_roots.size() == 0) begin
                $display("%0t unexpected result rm=%h", $time, o_root_minus);
                errors <= errors + 1;
            end else begin
                t_roots e;
                e = expected_roots.pop_front();
                if (o_root_minus !== e.rm || o_root_plus !== e.rp ||
                    o_root_count !== e.cnt || o_overflow !== e.ovf) begin
                    $display({"%0t mismatch exp rm=%h rp=%h cnt=%0d ovf=%b ",
                              "act rm=%h rp=%h cnt=%0d ovf=%b"},
                             $time, e.rm, e.rp, e.cnt, e.ovf,
                             o_root_minus, o_root_plus, o_root_count, o_overflow);
                    errors <= errors + 1;
                end
            end
        end
    end

    // Hold until the queue drains and every prediction has been matched.
    task automatic drain();
        while (pending_coefs.size() != 0 || i_start || expected_roots.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_tol(input logic [15:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tol = v;
    endtask

    task automatic push(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
        t_coef k;
        k.a = a;
        k.b = b;
        k.c = c;
        pending_coefs.push_back(k);
    endtask

    initial begin
        int pct[4];
        logic [15:0] tols[4];
        pct = '{0, 68, 9, 68};
        tols = '{16'd0, 16'd65535, 16'd3, 16'd300};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed: degenerate, linear, one-root, no-root and saturating cases.
        push(0, 0, 0);
        push(0, 0, 32'h10000);
        push(0, 32'h10000, 32'h20000);
        push(0, 32'h80000000, 32'h7fffffff);
        push(0, 1, 32'h7fffffff);
        push(32'h10000, 32'hfffe0000, 32'h10000);
        push(32'h10000, 0, 32'h10000);
        push(32'h10000, 0, 32'hffff0000);
        push(32'h80000000, 32'h80000000, 32'h80000000);
        push(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        push(32'h7fffffff, 32'h80000000, 32'h80000000);
        push(1, 32'h7fffffff, 0);
        push(32'hffffffff, 32'h80000000, 32'h7fffffff);
        push(32'h20000, 32'h30000, 32'h10000);
        push(2, 3, 1);
        for (int ph = 0; ph < 4; ph++) begin
            write_tol(tols[ph]);
            idle_pct = pct[ph];
            for (int n = 0; n < 175; n++)
                push(rand_coef(), rand_coef(), rand_coef());
            // Pause the sender until the pipeline is empty, then continue.
            if (ph == 1)
                drain();
        end
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && expected_roots.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        wait (cycles >= LIMIT);
        $display("status: fail");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/qrs_pkg.sv
rtl/qrs_sqrt_cell.sv
rtl/qrs_div_cell.sv
rtl/quadratic_root_solver.sv
test/tb.sv
